@@ src/fpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Fractal pattern pixel test - shared definitions
// Pattern codes, coordinate width and the constants of the base-3 digit
// pipeline.
// ----------------------------------------------------------------------------
package fpt_pkg;

   // Number of coordinate bits taken from each input field
   localparam int COORD_BITS = 16;

   // Pattern selector codes
   typedef enum logic [1:0] {
      KIND_CARPET     = 2'd0,
      KIND_TRIANGLE   = 2'd1,
      KIND_DUST       = 2'd2,
      KIND_ALL_FILLED = 2'd3
   } pattern_kind_type;

   // Number of base-3 digits needed to cover a value of the given bit width
   function automatic int ternary_digits(input int bits);
      longint unsigned p;
      int              n;
      p = 1;
      n = 0;
      for (int i = 0; i < 64; i++) begin
         if (p < (64'd1 << bits)) begin
            p = p * 3;
            n = n + 1;
         end
      end
      return n;
   endfunction

   localparam int NUM_DIGITS = ternary_digits(COORD_BITS);

   // Reciprocal of three, scaled by 2^(COORD_BITS+1) and rounded up; exact
   // quotient for every value below 2^COORD_BITS after the matching shift
   localparam longint unsigned RECIP_THREE = ((64'd1 << (COORD_BITS + 1)) + 64'd2) / 64'd3;

endpackage

@@ src/fractal_pattern_pixel_test.sv @@
// ----------------------------------------------------------------------------
// Fractal pattern pixel test
// Streaming test of pixel membership in a carpet, triangle or dust pattern.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries one pixel (col_x, row_y) and
// produces exactly one transfer on the rsp_ channel with the filled bit. The
// block accepts a new pixel every clock cycle while rsp_ is not stalled; the
// pipeline is one input register stage followed by one stage per base-3
// digit, each stage dividing both coordinates by three with a reciprocal
// multiply. A stalled rsp_ side holds the whole pipeline.
// The pattern is chosen through csr_data (0 carpet, 1 triangle, 2 Cantor
// dust, 3 every pixel filled) and is to be written while the pipeline is
// empty.
module fractal_pattern_pixel_test (
   input  logic       clock,
   input  logic       reset,
   // Pixel input: tdata = col_x[15:0], row_y[31:16]
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [31:0] req_tdata,
   // Result: tdata = filled[0], zero padding [7:1]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   // Pattern selector write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   localparam int CW  = fpt_pkg::COORD_BITS;
   localparam int ND  = fpt_pkg::NUM_DIGITS;
   localparam logic [CW-1:0] RECIP = CW'(fpt_pkg::RECIP_THREE);

   fpt_pkg::pattern_kind_type kind_ff;

   // Pipeline registers: stage 0 is the input stage, stage s holds the
   // quotients after s digits have been stripped
   logic [ND:0]               valid_ff;
   logic [CW-1:0]             x_ff     [0:ND];
   logic [CW-1:0]             y_ff     [0:ND];
   logic                      empty_ff [0:ND];
   fpt_pkg::pattern_kind_type pkind_ff [0:ND];

   logic [CW-1:0] x_in     [1:ND];
   logic [CW-1:0] y_in     [1:ND];
   logic          empty_in [1:ND];

   logic advance;

   assign advance    = !valid_ff[ND] || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= fpt_pkg::KIND_CARPET;
      end else if (csr_valid) begin
         kind_ff <= fpt_pkg::pattern_kind_type'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ND-1:0], req_tvalid};
      end
   end

   // Input stage: the triangle decision is complete here
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]     <= CW'(req_tdata[15:0]);
         y_ff[0]     <= CW'(req_tdata[31:16]);
         pkind_ff[0] <= kind_ff;
         empty_ff[0] <= (kind_ff == fpt_pkg::KIND_TRIANGLE) &&
                        (|(CW'(req_tdata[15:0]) & CW'(req_tdata[31:16])));
      end
   end

   for (genvar s = 1; s <= ND; s++) begin : g_digit
      logic [2*CW-1:0] prod_x;
      logic [2*CW-1:0] prod_y;
      logic [CW+1:0]   three_qx;
      logic [CW+1:0]   three_qy;
      logic [1:0]      dig_x;
      logic [1:0]      dig_y;
      logic            hit;

      always_comb begin
         prod_x   = (2*CW)'(x_ff[s-1]) * (2*CW)'(RECIP);
         prod_y   = (2*CW)'(y_ff[s-1]) * (2*CW)'(RECIP);
         x_in[s]  = CW'(prod_x >> (CW + 1));
         y_in[s]  = CW'(prod_y >> (CW + 1));
         three_qx = {2'b00, x_in[s]} + {1'b0, x_in[s], 1'b0};
         three_qy = {2'b00, y_in[s]} + {1'b0, y_in[s], 1'b0};
         dig_x    = 2'(x_ff[s-1] - three_qx[CW-1:0]);
         dig_y    = 2'(y_ff[s-1] - three_qy[CW-1:0]);
         case (pkind_ff[s-1])
            fpt_pkg::KIND_CARPET: hit = (dig_x == 2'd1) && (dig_y == 2'd1);
            fpt_pkg::KIND_DUST:   hit = (dig_x == 2'd1) || (dig_y == 2'd1);
            default:              hit = 1'b0;
         endcase
         empty_in[s] = empty_ff[s-1] || hit;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[s]     <= x_in[s];
            y_ff[s]     <= y_in[s];
            empty_ff[s] <= empty_in[s];
            pkind_ff[s] <= pkind_ff[s-1];
         end
      end
   end

   assign rsp_tvalid = valid_ff[ND];
   assign rsp_tdata  = {7'b0000000,
                        (pkind_ff[ND] == fpt_pkg::KIND_ALL_FILLED) || !empty_ff[ND]};

`ifndef NO_ASSERTIONS
   // No result may appear straight after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Intake follows the state of the output stage
   a_ready_link : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("intake not tied to output stall");

   // The all-filled pattern code fills every pixel
   a_all_filled : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && pkind_ff[ND] == fpt_pkg::KIND_ALL_FILLED) |-> rsp_tdata[0])
      else $error("pixel empty under all-filled code");

   // A stalled result holds its value
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");
`endif

endmodule
